// ===== rtl/msd_pkg.sv =====
package msd_pkg;

    // symbol kinds on the input tuser
    localparam logic [1:0] SYM_DOT      = 2'd0;
    localparam logic [1:0] SYM_DASH     = 2'd1;
    localparam logic [1:0] SYM_WORD_END = 2'd2;

    // configuration register indexes
    localparam logic CFG_AUTO_GAP_ENABLE = 1'b0;
    localparam logic CFG_GAP_THRESHOLD   = 1'b1;

    localparam logic [31:0] GAP_THRESHOLD_RESET = 32'd1000000;

    // letter length marks
    localparam logic [2:0] MAX_LETTER_LEN = 3'd5;
    localparam logic [2:0] LONG_MARK      = 3'd6;

    localparam logic [6:0] UNKNOWN_CHAR = 7'h3F;

    // closed letter handed from the front to the back
    typedef struct packed {
        logic [4:0] code_bits;
        logic [2:0] code_length;
        logic       word_end;
    } letter_cmd_t;

    // itu code to ascii, bit i of bits is symbol i, 1 for dash
    function automatic logic [6:0] decode_letter(input logic [2:0] len,
                                                 input logic [4:0] bits);
        logic [6:0] ch;
        ch = UNKNOWN_CHAR;
        case ({len, bits})
            {3'd2, 5'h02}: ch = 7'h41; // A
            {3'd4, 5'h01}: ch = 7'h42; // B
            {3'd4, 5'h05}: ch = 7'h43; // C
            {3'd3, 5'h01}: ch = 7'h44; // D
            {3'd1, 5'h00}: ch = 7'h45; // E
            {3'd4, 5'h04}: ch = 7'h46; // F
            {3'd3, 5'h03}: ch = 7'h47; // G
            {3'd4, 5'h00}: ch = 7'h48; // H
            {3'd2, 5'h00}: ch = 7'h49; // I
            {3'd4, 5'h0E}: ch = 7'h4A; // J
            {3'd3, 5'h05}: ch = 7'h4B; // K
            {3'd4, 5'h02}: ch = 7'h4C; // L
            {3'd2, 5'h03}: ch = 7'h4D; // M
            {3'd2, 5'h01}: ch = 7'h4E; // N
            {3'd3, 5'h07}: ch = 7'h4F; // O
            {3'd4, 5'h06}: ch = 7'h50; // P
            {3'd4, 5'h0B}: ch = 7'h51; // Q
            {3'd3, 5'h02}: ch = 7'h52; // R
            {3'd3, 5'h00}: ch = 7'h53; // S
            {3'd1, 5'h01}: ch = 7'h54; // T
            {3'd3, 5'h04}: ch = 7'h55; // U
            {3'd4, 5'h08}: ch = 7'h56; // V
            {3'd3, 5'h06}: ch = 7'h57; // W
            {3'd4, 5'h09}: ch = 7'h58; // X
            {3'd4, 5'h0D}: ch = 7'h59; // Y
            {3'd4, 5'h03}: ch = 7'h5A; // Z
            {3'd5, 5'h1F}: ch = 7'h30; // 0
            {3'd5, 5'h1E}: ch = 7'h31; // 1
            {3'd5, 5'h1C}: ch = 7'h32; // 2
            {3'd5, 5'h18}: ch = 7'h33; // 3
            {3'd5, 5'h10}: ch = 7'h34; // 4
            {3'd5, 5'h00}: ch = 7'h35; // 5
            {3'd5, 5'h01}: ch = 7'h36; // 6
            {3'd5, 5'h03}: ch = 7'h37; // 7
            {3'd5, 5'h07}: ch = 7'h38; // 8
            {3'd5, 5'h0F}: ch = 7'h39; // 9
            default:       ch = UNKNOWN_CHAR;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/morse_symbol_decoder.sv =====
// channel  direction  data                          sideband
// s_       in         tdata[31:0] idle_us           tuser[1:0] symbol
// m_       out        tdata[6:0] char_code, [7] 0   tlast word_end
// cfg_     in         index 0 auto_gap_enable, 1 gap_threshold_us
//
// one symbol per cycle while s_tready is high; a letter closed by a symbol goes
// through the queue write, then the output register, before it shows on m_
// aresetn is synchronous; it clears letter state, queue and output valid and resets config registers
// a stall on m_ fills the two-entry letter queue, then drops s_tready
module morse_symbol_decoder #(
    parameter int MAX_WORD_SYMBOLS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_addr,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // idle_us
    input  logic [1:0]  s_tuser,   // symbol
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_code, zero pad bit
    output logic        m_tlast    // word_end
);
    import msd_pkg::*;

    logic        q_full, q_not_empty, q_pop, cmd_push;
    letter_cmd_t push_cmd, head_cmd;

    assign s_tready = !q_full;

    msd_front #(
        .MAX_WORD_SYMBOLS(MAX_WORD_SYMBOLS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_addr(cfg_wr_addr),
        .cfg_wr_data(cfg_wr_data),
        .sym_accept (s_tvalid && s_tready),
        .symbol     (s_tuser),
        .idle_us    (s_tdata),
        .cmd_push   (cmd_push),
        .cmd        (push_cmd)
    );

    msd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head_cmd (head_cmd)
    );

    msd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(q_not_empty),
        .cmd      (head_cmd),
        .cmd_pop  (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/msd_front.sv =====
module msd_front #(
    parameter int MAX_WORD_SYMBOLS = 30
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_addr,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 sym_accept,
    input  logic [1:0]           symbol,
    input  logic [31:0]          idle_us,
    output logic                 cmd_push,
    output msd_pkg::letter_cmd_t cmd
);
    import msd_pkg::*;

    localparam int CNT_W = $clog2(MAX_WORD_SYMBOLS + 1);

    logic             auto_gap_reg;
    logic [31:0]      threshold_reg;
    logic [4:0]       bits_reg, bits_next;
    logic [2:0]       len_reg, len_next;
    logic [CNT_W-1:0] wcnt_reg, wcnt_next;

    logic       gap_close;
    logic [4:0] cur_bits;
    logic [2:0] cur_len;
    logic       word_full;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_gap_reg  <= 1'b0;
            threshold_reg <= GAP_THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                CFG_AUTO_GAP_ENABLE: auto_gap_reg  <= cfg_wr_data[0];
                CFG_GAP_THRESHOLD:   threshold_reg <= cfg_wr_data;
                default:             ;
            endcase
        end
    end

    assign word_full = (wcnt_reg >= CNT_W'(MAX_WORD_SYMBOLS));
    assign gap_close = auto_gap_reg && (idle_us > threshold_reg) && (len_reg != 3'd0);

    // letter as it stands after a gap close
    assign cur_bits = gap_close ? 5'd0 : bits_reg;
    assign cur_len  = gap_close ? 3'd0 : len_reg;

    // classify the symbol, push any letter it closes and update the letter under construction
    always_comb begin
        bits_next = bits_reg;
        len_next  = len_reg;
        wcnt_next = wcnt_reg;
        cmd_push  = 1'b0;
        cmd.code_bits   = bits_reg;
        cmd.code_length = len_reg;
        cmd.word_end    = 1'b0;
        if (sym_accept) begin
            case (symbol)
                SYM_WORD_END: begin
                    cmd_push     = 1'b1;
                    cmd.word_end = 1'b1;
                    bits_next    = 5'd0;
                    len_next     = 3'd0;
                    wcnt_next    = '0;
                end
                SYM_DOT, SYM_DASH: begin
                    if (!word_full) begin
                        cmd_push = gap_close;
                        if (cur_len < MAX_LETTER_LEN) begin
                            bits_next = cur_bits |
                                        (5'((symbol == SYM_DASH)) << cur_len);
                            len_next  = cur_len + 3'd1;
                        end else begin
                            bits_next = cur_bits;
                            len_next  = LONG_MARK;
                        end
                        wcnt_next = wcnt_reg + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg <= 5'd0;
            len_reg  <= 3'd0;
            wcnt_reg <= '0;
        end else begin
            bits_reg <= bits_next;
            len_reg  <= len_next;
            wcnt_reg <= wcnt_next;
        end
    end

endmodule

// ===== rtl/msd_queue.sv =====
module msd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  msd_pkg::letter_cmd_t push_cmd,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output msd_pkg::letter_cmd_t head_cmd
);
    import msd_pkg::*;

    letter_cmd_t mem [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/msd_back.sv =====
module msd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    input  msd_pkg::letter_cmd_t cmd,
    output logic                 cmd_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);
    import msd_pkg::*;

    logic       valid_reg;
    logic [6:0] char_reg;
    logic       last_reg;

    // take the next letter when the output register is free or draining
    assign cmd_pop = cmd_valid && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_tready) begin
            valid_reg <= cmd_valid;
        end
    end

    // decode into the output register
    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            char_reg <= decode_letter(cmd.code_length, cmd.code_bits);
            last_reg <= cmd.word_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/msd_checker.sv =====
module msd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // no word comes out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    // every character is a letter, a digit or the unknown mark
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == 8'h3F) ||
                     (m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
                     (m_tdata >= 8'h41 && m_tdata <= 8'h5A))
        else $error("result character outside decode set");

    // an idle block with an empty letter path offers input
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && $past(!m_tvalid) && $past(!s_tvalid, 2) && $past(!s_tvalid)
            && $past(aresetn, 2) |-> s_tready)
        else $error("input stalled with nothing pending");

endmodule

bind morse_symbol_decoder msd_checker u_msd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

// ===== tb/tb_morse_symbol_decoder.sv =====
module tb_morse_symbol_decoder;

    import msd_pkg::*;

    localparam int WORD_LIMIT     = 30;
    localparam int STALL_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_SYMBOLS  = 100;
    localparam int DIR_ROWS       = 25;
    localparam int GAP_ROWS_START = 16;

    // selector value the block must ignore
    localparam logic [1:0] SYM_NONE = 2'd3;
    localparam logic [6:0] CHAR_E   = 7'h45;

    typedef enum int {PACE_FULL, PACE_SPARSE, PACE_RANDOM} pace_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } char_word_t;

    typedef struct {
        logic [1:0]  sym;
        logic [31:0] idle;
        bit          typed;
        logic [6:0]  ch;
        bit          last;
    } dir_row_t;

    typedef struct {
        bit          gap_en;
        logic [31:0] thresh;
        pace_t       tx_pace;
        pace_t       rx_pace;
        bit          hold_mid;
        bit          drain_mid;
    } phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_addr = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // idle_us
    logic [1:0]  s_tuser = '0;     // symbol
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // char_code, zero pad bit
    logic        m_tlast;          // word_end

    // mirror of the decoder: configuration and letter state
    bit          gap_en = 1'b0;
    logic [31:0] gap_thresh = GAP_THRESHOLD_RESET;
    logic [4:0]  letter_bits = '0;
    logic [2:0]  letter_len = '0;
    int          word_syms = 0;

    char_word_t  expected_chars[$];
    int          mismatches = 0;
    int          symbols_taken = 0;
    int          stall_cycles = 0;
    int          rx_hold_req = 0;
    bit          pause_for_drain = 1'b0;
    pace_t       tx_pace = PACE_RANDOM;
    pace_t       rx_pace = PACE_RANDOM;

    // itu glyphs in the order of itu_chars
    string itu_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    string itu_glyphs [36] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."
    };

    // extremes, every symbol kind, long letter, empty word end, ignored selector,
    // then the gap rows: gap at letter start, idle equal to threshold, gap close
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{SYM_WORD_END, 32'h0000_0000, 1'b1, UNKNOWN_CHAR, 1'b1},
        '{SYM_DOT,      32'hFFFF_FFFF, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_WORD_END, 32'h0000_0000, 1'b1, CHAR_E,       1'b1},
        '{SYM_DASH,     32'h0000_0000, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DASH,     32'h0000_0001, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DASH,     32'h8000_0000, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DASH,     32'h0000_0000, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DASH,     32'h0000_0000, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DASH,     32'h7FFF_FFFF, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DASH,     32'h0000_0000, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_WORD_END, 32'hFFFF_FFFF, 1'b1, UNKNOWN_CHAR, 1'b1},
        '{SYM_NONE,     32'hFFFF_FFFF, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DOT,      32'h5555_5555, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DASH,     32'hAAAA_AAAA, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_NONE,     32'h0000_0000, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_WORD_END, 32'h0000_0000, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DOT,      32'd500,       1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DASH,     32'd100,       1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DOT,      32'd101,       1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DOT,      32'd0,         1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_WORD_END, 32'hFFFF_FFFF, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DASH,     32'd0,         1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_DASH,     32'hFFFF_FFFF, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_NONE,     32'hFFFF_FFFF, 1'b0, UNKNOWN_CHAR, 1'b0},
        '{SYM_WORD_END, 32'd0,         1'b0, UNKNOWN_CHAR, 1'b0}
    };

    morse_symbol_decoder #(
        .MAX_WORD_SYMBOLS(WORD_LIMIT)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_addr(cfg_wr_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // letter code to ascii, unknown or overlong codes give the question mark
    function automatic logic [6:0] char_of(input logic [2:0] len, input logic [4:0] bits);
        logic [4:0] pattern;
        byte        c;
        if (len == 3'd0 || len > MAX_LETTER_LEN)
            return UNKNOWN_CHAR;
        for (int i = 0; i < 36; i++) begin
            pattern = '0;
            for (int k = 0; k < itu_glyphs[i].len(); k++)
                if (itu_glyphs[i].getc(k) == "-")
                    pattern[k] = 1'b1;
            if (itu_glyphs[i].len() == int'(len) && pattern == bits) begin
                c = itu_chars.getc(i);
                return c[6:0];
            end
        end
        return UNKNOWN_CHAR;
    endfunction

    // advance the mirror by one symbol, give the char word it closes if any
    task automatic decode_symbol(input logic [1:0] sym, input logic [31:0] idle,
                                 output bit fired, output bit used, output char_word_t got);
        fired = 1'b0;
        used  = 1'b0;
        got   = '{UNKNOWN_CHAR, 1'b0};
        if (sym == SYM_WORD_END) begin
            fired       = 1'b1;
            used        = 1'b1;
            got         = '{char_of(letter_len, letter_bits), 1'b1};
            letter_bits = '0;
            letter_len  = '0;
            word_syms   = 0;
        end else if (sym != SYM_NONE && word_syms < WORD_LIMIT) begin
            used = 1'b1;
            // idle gap closes a started letter
            if (gap_en && idle > gap_thresh && letter_len != 3'd0) begin
                fired       = 1'b1;
                got         = '{char_of(letter_len, letter_bits), 1'b0};
                letter_bits = '0;
                letter_len  = '0;
            end
            if (letter_len < MAX_LETTER_LEN) begin
                if (sym == SYM_DASH)
                    letter_bits[letter_len] = 1'b1;
                letter_len = letter_len + 3'd1;
            end else begin
                letter_len = LONG_MARK;
            end
            word_syms++;
        end
    endtask

    function automatic int draw_gap(input pace_t pace);
        case (pace)
            PACE_FULL:   return 0;
            PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
            default:     return $urandom_range(0, 14);
        endcase
    endfunction

    // idle time around the current threshold, mostly above it when a gap is wanted
    function automatic logic [31:0] pick_idle(input bit want_gap);
        longint unsigned t;
        int              r;
        t = 64'(gap_thresh);
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom;
        if (want_gap) begin
            if (t == 64'hFFFF_FFFF)
                return $urandom;
            if (r == 1)
                return 32'(t + 1);
            if (r == 2)
                return 32'hFFFF_FFFF;
            return 32'(t + 1 + ({$urandom, $urandom} % (64'hFFFF_FFFF - t)));
        end
        if (r == 1)
            return 32'(t);
        if (r == 2)
            return 32'd0;
        return 32'({$urandom, $urandom} % (t + 1));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic write_reg(input logic addr, input logic [31:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
        if (addr == CFG_AUTO_GAP_ENABLE)
            gap_en = data[0];
        else
            gap_thresh = data;
        cfg_wr_en <= 1'b0;
    endtask

    // offer one symbol word and hold it until taken
    task automatic send_symbol(input logic [1:0] sym, input logic [31:0] idle,
                               input bit typed, input logic [6:0] typed_ch,
                               input bit typed_last);
        int         gap;
        bit         fired;
        bit         used;
        char_word_t got;
        gap = draw_gap(tx_pace);
        if (gap > 0 || (pause_for_drain && expected_chars.size() != 0)) begin
            s_tvalid <= 1'b0;
            while (pause_for_drain && expected_chars.size() != 0)
                @(posedge aclk);
            repeat (gap) @(posedge aclk);
        end
        pause_for_drain = 1'b0;
        s_tvalid <= 1'b1;
        s_tuser  <= sym;
        s_tdata  <= idle;
        @(posedge aclk);
        while (s_tready !== 1'b1)
            @(posedge aclk);
        decode_symbol(sym, idle, fired, used, got);
        if (typed)
            expected_chars.push_back('{typed_ch, typed_last});
        else if (fired)
            expected_chars.push_back(got);
        if (used)
            symbols_taken++;
    endtask

    // mostly well formed words, with noise, overlong letters and runaway words
    task automatic send_random_word();
        int n_letters;
        int n_syms;
        bit long_word;
        long_word = ($urandom_range(0, 11) == 0);
        n_letters = long_word ? $urandom_range(8, 12) : $urandom_range(1, 5);
        if ($urandom_range(0, 19) == 0)
            send_symbol(SYM_WORD_END, $urandom, 1'b0, UNKNOWN_CHAR, 1'b0);
        for (int k = 0; k < n_letters; k++) begin
            if (long_word)
                n_syms = $urandom_range(4, 6);
            else
                n_syms = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8)
                                                     : $urandom_range(1, 5);
            for (int j = 0; j < n_syms; j++) begin
                if ($urandom_range(0, 19) == 0)
                    send_symbol(SYM_NONE, $urandom, 1'b0, UNKNOWN_CHAR, 1'b0);
                send_symbol($urandom_range(0, 1) ? SYM_DASH : SYM_DOT,
                            pick_idle(j == 0 && k != 0), 1'b0, UNKNOWN_CHAR, 1'b0);
            end
        end
        if ($urandom_range(0, 15) != 0)
            send_symbol(SYM_WORD_END, pick_idle(1'b1), 1'b0, UNKNOWN_CHAR, 1'b0);
    endtask

    // drop valid, let every expected word arrive and the pipe settle
    task automatic close_phase();
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side: random stalls, one long hold on request
    initial begin : char_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = (rx_hold_req > 0) ? rx_hold_req : draw_gap(rx_pace);
            rx_hold_req = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1)
                @(posedge aclk);
        end
    end

    // compare each char word with the oldest expectation
    always @(posedge aclk) begin : char_check
        char_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected word char %h last %b", m_tdata, m_tlast));
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata !== {1'b0, want.ch})
                    report_mismatch($sformatf("char %h, want %h", m_tdata, want.ch));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("word_end %b, want %b", m_tlast, want.last));
            end
        end
    end

    // no handshake for too long means a hang
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        phase_t phases [5];
        int     phase_start;
        bit     mid_done;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, gap rows run with gaps on and a small threshold
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == GAP_ROWS_START) begin
                close_phase();
                write_reg(CFG_AUTO_GAP_ENABLE, 32'd1);
                write_reg(CFG_GAP_THRESHOLD, 32'd100);
            end
            send_symbol(dir_rows[i].sym, dir_rows[i].idle, dir_rows[i].typed,
                        dir_rows[i].ch, dir_rows[i].last);
        end

        phases[0] = '{1'b1, 32'h0000_0000, PACE_RANDOM, PACE_RANDOM, 1'b1, 1'b0};
        phases[1] = '{1'b1, 32'hFFFF_FFFF, PACE_FULL,   PACE_FULL,   1'b0, 1'b0};
        phases[2] = '{1'b0, $urandom,      PACE_SPARSE, PACE_RANDOM, 1'b0, 1'b0};
        phases[3] = '{1'b1, $urandom_range(1, 5000), PACE_RANDOM, PACE_SPARSE, 1'b0, 1'b1};
        phases[4] = '{1'b1, $urandom,      PACE_RANDOM, PACE_RANDOM, 1'b0, 1'b0};

        // random phases, each with its own setting and pacing
        for (int p = 0; p < 5; p++) begin
            close_phase();
            write_reg(CFG_AUTO_GAP_ENABLE, {31'd0, phases[p].gap_en});
            write_reg(CFG_GAP_THRESHOLD, phases[p].thresh);
            tx_pace     = phases[p].tx_pace;
            rx_pace     = phases[p].rx_pace;
            phase_start = symbols_taken;
            mid_done    = 1'b0;
            while (symbols_taken - phase_start < PHASE_SYMBOLS) begin
                if (!mid_done && symbols_taken - phase_start >= PHASE_SYMBOLS / 2) begin
                    mid_done = 1'b1;
                    if (phases[p].hold_mid)
                        rx_hold_req = LONG_HOLD;
                    if (phases[p].drain_mid)
                        pause_for_drain = 1'b1;
                end
                send_random_word();
            end
        end
        close_phase();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/msd_pkg.sv
rtl/msd_front.sv
rtl/msd_queue.sv
rtl/msd_back.sv
rtl/morse_symbol_decoder.sv
rtl/msd_checker.sv
tb/tb_morse_symbol_decoder.sv
